// ===== rtl/core/realtime_priority_run_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the real-time run queue
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef REALTIME_PRIORITY_RUN_QUEUE_MACROS_SVH
`define REALTIME_PRIORITY_RUN_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define RPRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rprq assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define RPRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rprq assertion failed");
`else
`define RPRQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RPRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/rprq_pkg.sv =====
// ----------------------------------------------------------------------------
// Real-time run queue package
// Sizes, operation codes, table entry layouts and the level priority encoder.
// ----------------------------------------------------------------------------
package rprq_pkg;

    localparam int NUM_THREADS = 64;
    localparam int NUM_LEVELS  = 32;

    localparam int TID_W   = $clog2(NUM_THREADS);
    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int SLICE_W = 16;
    localparam int MODE_W  = 3;

    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);

    typedef logic [TID_W-1:0]      t_tid;
    typedef logic [LVL_W-1:0]      t_lvl;
    typedef logic [SLICE_W-1:0]    t_slice;
    typedef logic [MODE_W-1:0]     t_mode_bits;
    typedef logic [NUM_LEVELS-1:0] t_bitmap;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT   = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_NEXT   = 3'd3,
        MODE_TICK   = 3'd4
    } t_mode;

    // One entry per thread: list links, the level it is queued at, its slice.
    typedef struct packed {
        t_tid   next_id;
        t_tid   prev_id;
        t_lvl   lvl;
        t_slice slice_left;
    } t_thread_entry;

    // One entry per priority level: first and last queued thread.
    typedef struct packed {
        t_tid head;
        t_tid tail;
    } t_level_entry;

    // Highest set bit of a non-empty bitmap.
    function automatic t_lvl find_top_level(input t_bitmap bm);
        t_lvl lvl;
        lvl = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (bm[i]) begin
                lvl = LVL_W'(i);
            end
        end
        return lvl;
    endfunction

endpackage

// ===== rtl/core/realtime_priority_run_queue.sv =====
// ----------------------------------------------------------------------------
// Real-time run queue
// One FIFO of thread ids per priority level, kept as doubly linked lists in
// a thread table and a level table, with a bitmap of non-empty levels.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Init slice and a round-robin tick go
// through S_SLICE, add to an empty level through S_ADD_SELF, add to a
// non-empty level through S_ADD_TAIL, S_ADD_LINK, S_ADD_SELF, remove through
// S_RM_T, S_RM_L (head or tail of its level) and also S_RM_P, S_RM_N (middle),
// and get next through S_NX_HEAD and on as a remove, since it always unlinks
// the head of its level; all then end in S_DONE, as does a request that
// touches no table. The tables have one read and one write port each. A
// finished result waits in an output register while the next request is
// accepted; a request whose result is ready while that register is still full
// holds in S_DONE until the register is taken. No clearing pass is needed after reset.
`include "realtime_priority_run_queue_macros.svh"

module realtime_priority_run_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_slice_ticks_we,
    input  rprq_pkg::t_slice          i_slice_ticks,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  rprq_pkg::t_mode_bits      i_mode,
    input  rprq_pkg::t_tid            i_thread_id,
    input  rprq_pkg::t_lvl            i_priority_req,
    input  logic                      i_round_robin,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_picked_valid,
    output rprq_pkg::t_tid            o_picked_id,
    output rprq_pkg::t_lvl            o_picked_priority,
    output logic                      o_reschedule
);

    import rprq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SLICE    = 11'b000_0000_0010,
        S_ADD_TAIL = 11'b000_0000_0100,
        S_ADD_LINK = 11'b000_0000_1000,
        S_ADD_SELF = 11'b000_0001_0000,
        S_NX_HEAD  = 11'b000_0010_0000,
        S_RM_T     = 11'b000_0100_0000,
        S_RM_L     = 11'b000_1000_0000,
        S_RM_P     = 11'b001_0000_0000,
        S_RM_N     = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    // Control state.
    t_state                 r_state, n_state;
    t_bitmap                r_bitmap, n_bitmap;
    logic [NUM_THREADS-1:0] r_queued, n_queued;
    t_lvl                   r_run_prio, n_run_prio;
    logic                   r_run_rt, n_run_rt;
    t_slice                 r_slice_ticks;
    logic                   r_out_valid, n_out_valid;

    // Request and work registers.
    t_mode_bits r_mode, n_mode;
    t_tid       r_tid, n_tid;
    t_lvl       r_prio, n_prio;
    t_lvl       r_lvl, n_lvl;
    t_tid       r_p, n_p;
    t_tid       r_n, n_n;
    t_tid       r_head, n_head;
    logic       r_res_valid, n_res_valid;
    t_tid       r_res_id, n_res_id;
    t_lvl       r_res_prio, n_res_prio;
    logic       r_res_resched, n_res_resched;
    logic       r_out_pvalid, n_out_pvalid;
    t_tid       r_out_id, n_out_id;
    t_lvl       r_out_prio, n_out_prio;
    logic       r_out_resched, n_out_resched;

    // Table ports.
    logic          t_we, t_re;
    t_tid          t_waddr, t_raddr;
    t_thread_entry t_wdata, t_rdata;
    logic          l_we, l_re;
    t_lvl          l_waddr, l_raddr;
    t_level_entry  l_wdata, l_rdata;

    logic in_fire;
    t_lvl top_lvl;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign top_lvl    = find_top_level(r_bitmap);

    rprq_ram #(
        .WIDTH($bits(t_thread_entry)),
        .DEPTH(NUM_THREADS)
    ) u_thread_ram (
        .i_clk  (i_clk),
        .i_we   (t_we),
        .i_waddr(t_waddr),
        .i_wdata(t_wdata),
        .i_re   (t_re),
        .i_raddr(t_raddr),
        .o_rdata(t_rdata)
    );

    rprq_ram #(
        .WIDTH($bits(t_level_entry)),
        .DEPTH(NUM_LEVELS)
    ) u_level_ram (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(l_waddr),
        .i_wdata(l_wdata),
        .i_re   (l_re),
        .i_raddr(l_raddr),
        .o_rdata(l_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_bitmap      = r_bitmap;
        n_queued      = r_queued;
        n_run_prio    = r_run_prio;
        n_run_rt      = r_run_rt;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_mode        = r_mode;
        n_tid         = r_tid;
        n_prio        = r_prio;
        n_lvl         = r_lvl;
        n_p           = r_p;
        n_n           = r_n;
        n_head        = r_head;
        n_res_valid   = r_res_valid;
        n_res_id      = r_res_id;
        n_res_prio    = r_res_prio;
        n_res_resched = r_res_resched;
        n_out_pvalid  = r_out_pvalid;
        n_out_id      = r_out_id;
        n_out_prio    = r_out_prio;
        n_out_resched = r_out_resched;

        t_we    = 1'b0;
        t_waddr = r_tid;
        t_wdata = t_rdata;
        t_re    = 1'b0;
        t_raddr = r_tid;
        l_we    = 1'b0;
        l_waddr = r_lvl;
        l_wdata = l_rdata;
        l_re    = 1'b0;
        l_raddr = r_lvl;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode        = i_mode;
                    n_tid         = i_thread_id;
                    n_prio        = i_priority_req;
                    n_res_valid   = 1'b0;
                    n_res_id      = '0;
                    n_res_prio    = '0;
                    n_res_resched = 1'b0;
                    n_state       = S_DONE;
                    case (i_mode)
                        MODE_INIT: begin
                            t_re    = 1'b1;
                            t_raddr = i_thread_id;
                            n_state = S_SLICE;
                        end
                        MODE_TICK: begin
                            if (i_round_robin) begin
                                t_re    = 1'b1;
                                t_raddr = i_thread_id;
                                n_state = S_SLICE;
                            end
                        end
                        MODE_ADD: begin
                            if (!r_queued[i_thread_id]) begin
                                n_res_resched = !r_run_rt || (i_priority_req > r_run_prio);
                                if (r_bitmap[i_priority_req]) begin
                                    l_re    = 1'b1;
                                    l_raddr = i_priority_req;
                                    n_state = S_ADD_TAIL;
                                end else begin
                                    // Empty level: the thread is head and tail,
                                    // and links to itself.
                                    t_re    = 1'b1;
                                    t_raddr = i_thread_id;
                                    n_p     = i_thread_id;
                                    n_head  = i_thread_id;
                                    n_state = S_ADD_SELF;
                                end
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_queued[i_thread_id]) begin
                                t_re    = 1'b1;
                                t_raddr = i_thread_id;
                                n_state = S_RM_T;
                            end
                        end
                        MODE_NEXT: begin
                            if (r_bitmap == '0) begin
                                n_run_rt = 1'b0;
                            end else begin
                                n_res_valid = 1'b1;
                                n_res_prio  = top_lvl;
                                n_run_prio  = top_lvl;
                                n_run_rt    = 1'b1;
                                l_re        = 1'b1;
                                l_raddr     = top_lvl;
                                n_state     = S_NX_HEAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SLICE: begin
                t_we    = 1'b1;
                t_waddr = r_tid;
                if ((r_mode == MODE_TICK) && (t_rdata.slice_left > SLICE_W'(1))) begin
                    t_wdata.slice_left = t_rdata.slice_left - SLICE_W'(1);
                end else begin
                    t_wdata.slice_left = r_slice_ticks;
                    n_res_resched      = (r_mode == MODE_TICK);
                end
                n_state = S_DONE;
            end
            S_ADD_TAIL: begin
                n_head  = l_rdata.head;
                n_p     = l_rdata.tail;
                t_re    = 1'b1;
                t_raddr = l_rdata.tail;
                n_state = S_ADD_LINK;
            end
            S_ADD_LINK: begin
                t_we            = 1'b1;
                t_waddr         = r_p;
                t_wdata.next_id = r_tid;
                t_re            = 1'b1;
                t_raddr         = r_tid;
                n_state         = S_ADD_SELF;
            end
            S_ADD_SELF: begin
                t_we            = 1'b1;
                t_waddr         = r_tid;
                t_wdata.next_id = r_tid;
                t_wdata.prev_id = r_p;
                t_wdata.lvl     = r_prio;
                l_we            = 1'b1;
                l_waddr         = r_prio;
                l_wdata.head    = r_head;
                l_wdata.tail    = r_tid;
                n_bitmap[r_prio] = 1'b1;
                n_queued[r_tid]  = 1'b1;
                n_state          = S_DONE;
            end
            S_NX_HEAD: begin
                n_tid    = l_rdata.head;
                n_res_id = l_rdata.head;
                t_re     = 1'b1;
                t_raddr  = l_rdata.head;
                n_state  = S_RM_T;
            end
            S_RM_T: begin
                n_lvl   = t_rdata.lvl;
                n_p     = t_rdata.prev_id;
                n_n     = t_rdata.next_id;
                l_re    = 1'b1;
                l_raddr = t_rdata.lvl;
                n_state = S_RM_L;
            end
            S_RM_L: begin
                n_queued[r_tid] = 1'b0;
                n_state         = S_DONE;
                if (l_rdata.head == r_tid) begin
                    if (l_rdata.tail == r_tid) begin
                        n_bitmap[r_lvl] = 1'b0;
                    end else begin
                        l_we         = 1'b1;
                        l_wdata.head = r_n;
                    end
                end else if (l_rdata.tail == r_tid) begin
                    l_we         = 1'b1;
                    l_wdata.tail = r_p;
                end else begin
                    // Middle of the list: patch both neighbors in turn.
                    t_re    = 1'b1;
                    t_raddr = r_p;
                    n_state = S_RM_P;
                end
            end
            S_RM_P: begin
                t_we            = 1'b1;
                t_waddr         = r_p;
                t_wdata.next_id = r_n;
                t_re            = 1'b1;
                t_raddr         = r_n;
                n_state         = S_RM_N;
            end
            S_RM_N: begin
                t_we            = 1'b1;
                t_waddr         = r_n;
                t_wdata.prev_id = r_p;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_pvalid  = r_res_valid;
                    n_out_id      = r_res_id;
                    n_out_prio    = r_res_prio;
                    n_out_resched = r_res_resched;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_bitmap      <= '0;
            r_queued      <= '0;
            r_run_prio    <= '0;
            r_run_rt      <= 1'b0;
            r_slice_ticks <= SLICE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bitmap    <= n_bitmap;
            r_queued    <= n_queued;
            r_run_prio  <= n_run_prio;
            r_run_rt    <= n_run_rt;
            r_out_valid <= n_out_valid;
            if (i_slice_ticks_we) begin
                r_slice_ticks <= i_slice_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_tid         <= n_tid;
        r_prio        <= n_prio;
        r_lvl         <= n_lvl;
        r_p           <= n_p;
        r_n           <= n_n;
        r_head        <= n_head;
        r_res_valid   <= n_res_valid;
        r_res_id      <= n_res_id;
        r_res_prio    <= n_res_prio;
        r_res_resched <= n_res_resched;
        r_out_pvalid  <= n_out_pvalid;
        r_out_id      <= n_out_id;
        r_out_prio    <= n_out_prio;
        r_out_resched <= n_out_resched;
    end

    assign o_out_valid       = r_out_valid;
    assign o_picked_valid    = r_out_pvalid;
    assign o_picked_id       = r_out_id;
    assign o_picked_priority = r_out_prio;
    assign o_reschedule      = r_out_resched;

    // A write and a read of the same thread entry in one cycle would return stale data.
    `RPRQ_ASSERT_NOW(a_no_thread_rw_clash, i_clk, i_rst_n, t_we && t_re, t_waddr != t_raddr)
    `RPRQ_ASSERT_NEXT(a_next_sets_running, i_clk, i_rst_n, in_fire && (i_mode == MODE_NEXT) && (r_bitmap != '0), r_run_rt && (r_run_prio == $past(top_lvl)))
    `RPRQ_ASSERT_NEXT(a_double_add_ignored, i_clk, i_rst_n, in_fire && (i_mode == MODE_ADD) && r_queued[i_thread_id], $stable(r_bitmap) && (r_state == S_DONE))
    `RPRQ_ASSERT_NOW(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DONE))

endmodule

// ===== rtl/core/rprq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the real-time run queue
// Sends scheduler requests (init slice, add, remove, get next, tick and
// undefined modes) with random gaps and output stalls. Each result is checked
// against a behavioral model of the per-level FIFOs, the running thread and
// the per-thread time slices. The slice length is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rprq_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic picked_valid;
        t_tid picked_id;
        t_lvl picked_priority;
        logic reschedule;
    } t_outcome;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_slice_ticks_we = 1'b0;
    t_slice     i_slice_ticks = SLICE_RESET;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_mode_bits i_mode = '0;
    t_tid       i_thread_id = '0;
    t_lvl       i_priority_req = '0;
    logic       i_round_robin = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_picked_valid;
    t_tid       o_picked_id;
    t_lvl       o_picked_priority;
    logic       o_reschedule;

    // Model of the run queue.
    t_tid   level_fifo[NUM_LEVELS][$];
    logic   thread_queued[NUM_THREADS];
    t_lvl   thread_level[NUM_THREADS];
    t_slice slice_left[NUM_THREADS];
    logic   slice_loaded[NUM_THREADS];
    t_slice slice_ticks_cfg = SLICE_RESET;
    t_lvl   running_prio = '0;
    logic   running_rt = 1'b0;

    t_outcome pending_outcomes[$];

    int   fail_count = 0;
    int   results_checked = 0;
    int   picks_seen = 0;
    int   reschedules_seen = 0;
    int   mode_count[8];
    int   quiet_cycles = 0;
    logic request_held = 1'b0;
    logic steady_stretch = 1'b0;
    int   stretch_left = 0;
    int   stall_left = 0;
    t_lvl hot_levels[4];

    realtime_priority_run_queue dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_slice_ticks_we  (i_slice_ticks_we),
        .i_slice_ticks     (i_slice_ticks),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_thread_id       (i_thread_id),
        .i_priority_req    (i_priority_req),
        .i_round_robin     (i_round_robin),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_picked_valid    (o_picked_valid),
        .o_picked_id       (o_picked_id),
        .o_picked_priority (o_picked_priority),
        .o_reschedule      (o_reschedule)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < NUM_THREADS; i++) begin
            thread_queued[i] = 1'b0;
            thread_level[i]  = '0;
            slice_left[i]    = '0;
            slice_loaded[i]  = 1'b0;
        end
        for (int i = 0; i < 8; i++) begin
            mode_count[i] = 0;
        end
    end

    function automatic t_outcome run_queue_outcome(input t_mode_bits mode, input t_tid tid,
                                                   input t_lvl prio, input logic rr);
        t_outcome res;
        int       top;
        t_lvl     lvl;
        res.picked_valid    = 1'b0;
        res.picked_id       = '0;
        res.picked_priority = '0;
        res.reschedule      = 1'b0;
        case (mode)
            MODE_INIT: begin
                slice_left[tid]   = slice_ticks_cfg;
                slice_loaded[tid] = 1'b1;
            end
            MODE_ADD: begin
                if (!thread_queued[tid]) begin
                    level_fifo[prio].push_back(tid);
                    thread_queued[tid] = 1'b1;
                    thread_level[tid]  = prio;
                    res.reschedule = !running_rt || (prio > running_prio);
                end
            end
            MODE_REMOVE: begin
                if (thread_queued[tid]) begin
                    lvl = thread_level[tid];
                    for (int i = 0; i < level_fifo[lvl].size(); i++) begin
                        if (level_fifo[lvl][i] == tid) begin
                            level_fifo[lvl].delete(i);
                            break;
                        end
                    end
                    thread_queued[tid] = 1'b0;
                end
            end
            MODE_NEXT: begin
                top = -1;
                for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
                    if (top < 0 && level_fifo[l].size() != 0) begin
                        top = l;
                    end
                end
                if (top < 0) begin
                    running_rt = 1'b0;
                end else begin
                    res.picked_id = level_fifo[top].pop_front();
                    thread_queued[res.picked_id] = 1'b0;
                    res.picked_valid    = 1'b1;
                    res.picked_priority = t_lvl'(top);
                    running_prio = t_lvl'(top);
                    running_rt   = 1'b1;
                end
            end
            MODE_TICK: begin
                if (rr) begin
                    if (slice_left[tid] <= 1) begin
                        slice_left[tid] = slice_ticks_cfg;
                        res.reschedule  = 1'b1;
                    end else begin
                        slice_left[tid] = slice_left[tid] - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Alternates stretches of random idling with stretches of none.
    always @(posedge i_clk) begin
        if (stretch_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                steady_stretch <= 1'b1;
                stretch_left   <= $urandom_range(20, 80);
            end else begin
                steady_stretch <= 1'b0;
                stretch_left   <= $urandom_range(30, 150);
            end
        end else begin
            stretch_left <= stretch_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_receiver
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_stretch) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (roll < 20) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 2);
        end else if (roll < 23) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(10, 40);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_checker
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with none expected: valid %0d id %0d prio %0d resched %0d",
                         $time, o_picked_valid, o_picked_id, o_picked_priority, o_reschedule);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (want.picked_valid) picks_seen++;
                if (want.reschedule) reschedules_seen++;
                check_field("picked_valid", want.picked_valid, o_picked_valid);
                check_field("picked_id", want.picked_id, o_picked_id);
                check_field("picked_priority", want.picked_priority, o_picked_priority);
                check_field("reschedule", want.reschedule, o_reschedule);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: timeout, nothing moved for %0d cycles", $time, QUIET_LIMIT);
        $display("** realtime_priority_run_queue: FAILED **");
        $finish;
    end

    task automatic send_request(input t_mode_bits mode, input t_tid tid, input t_lvl prio,
                                input logic rr);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_stretch || roll < 55) begin
            gap = 0;
        end else if (roll < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            if (request_held) begin
                i_in_valid   <= 1'b0;
                request_held = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_thread_id    <= tid;
        i_priority_req <= prio;
        i_round_robin  <= rr;
        request_held   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_outcomes.push_back(run_queue_outcome(mode, tid, prio, rr));
        mode_count[mode]++;
    endtask

    task automatic wait_drained();
        if (request_held) begin
            i_in_valid   <= 1'b0;
            request_held = 1'b0;
            @(posedge i_clk);
        end
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Register writes only happen with no request in flight.
    task automatic write_slice_ticks(input t_slice value);
        wait_drained();
        i_slice_ticks_we <= 1'b1;
        i_slice_ticks    <= value;
        @(posedge i_clk);
        slice_ticks_cfg  = value;
        i_slice_ticks_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_unknown_modes();
        send_request(3'd5, 6'd63, 5'd31, 1'b1);
        send_request(3'd6, 6'd0, 5'd0, 1'b0);
        send_request(3'd7, 6'd42, 5'd21, 1'b1);
    endtask

    task automatic test_get_next_empty();
        send_request(MODE_NEXT, 6'd9, 5'd4, 1'b0);
    endtask

    // With no real-time thread running, every add of an unqueued thread asks for preemption.
    task automatic test_add_preempt();
        send_request(MODE_ADD, 6'd0, 5'd0, 1'b0);
        send_request(MODE_ADD, 6'd63, 5'd31, 1'b1);
        send_request(MODE_ADD, 6'd5, 5'd31, 1'b0);
        send_request(MODE_ADD, 6'd0, 5'd17, 1'b0);
    endtask

    task automatic test_get_next();
        send_request(MODE_NEXT, 6'd0, 5'd0, 1'b0);
        send_request(MODE_ADD, 6'd7, 5'd31, 1'b0);
        send_request(MODE_ADD, 6'd8, 5'd0, 1'b1);
        send_request(MODE_NEXT, 6'd63, 5'd31, 1'b1);
    endtask

    // Removal from the middle, the tail, a sole entry, and of a thread not queued.
    task automatic test_remove_positions();
        send_request(MODE_ADD, 6'd10, 5'd3, 1'b0);
        send_request(MODE_ADD, 6'd11, 5'd3, 1'b0);
        send_request(MODE_ADD, 6'd12, 5'd3, 1'b0);
        send_request(MODE_REMOVE, 6'd11, 5'd30, 1'b0);
        send_request(MODE_REMOVE, 6'd12, 5'd3, 1'b1);
        send_request(MODE_REMOVE, 6'd10, 5'd0, 1'b0);
        send_request(MODE_REMOVE, 6'd10, 5'd3, 1'b0);
    endtask

    task automatic test_slice_reload();
        write_slice_ticks(16'd2);
        send_request(MODE_INIT, 6'd1, 5'd0, 1'b1);
        send_request(MODE_TICK, 6'd1, 5'd0, 1'b0);
        send_request(MODE_TICK, 6'd1, 5'd0, 1'b1);
        send_request(MODE_TICK, 6'd1, 5'd0, 1'b1);
        // A zero slice length makes every tick expire.
        write_slice_ticks(16'd0);
        send_request(MODE_INIT, 6'd62, 5'd0, 1'b0);
        send_request(MODE_TICK, 6'd62, 5'd0, 1'b1);
        send_request(MODE_TICK, 6'd62, 5'd0, 1'b1);
    endtask

    // Mostly well-formed traffic: adds of idle threads onto a few busy levels,
    // removes of queued threads, and ticks of threads whose slice was loaded.
    task automatic test_random_traffic(input t_slice slice_len, input int count);
        t_tid       pool[$];
        t_mode_bits mode;
        t_tid       tid;
        t_lvl       prio;
        logic       rr;
        int         pick;
        write_slice_ticks(slice_len);
        hot_levels[0] = 5'd0;
        hot_levels[1] = 5'd31;
        hot_levels[2] = t_lvl'($urandom);
        hot_levels[3] = t_lvl'($urandom);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            tid  = t_tid'($urandom);
            prio = t_lvl'($urandom);
            rr   = 1'($urandom);
            pool.delete();
            if (pick < 30) begin
                mode = MODE_ADD;
                if ($urandom_range(0, 1) == 0) prio = hot_levels[$urandom_range(0, 3)];
                for (int i = 0; i < NUM_THREADS; i++) begin
                    if (!thread_queued[i]) pool.push_back(t_tid'(i));
                end
                if (pool.size() != 0 && $urandom_range(0, 3) != 0) begin
                    tid = pool[$urandom_range(0, pool.size() - 1)];
                end
            end else if (pick < 50) begin
                mode = MODE_NEXT;
            end else if (pick < 65) begin
                mode = MODE_REMOVE;
                for (int i = 0; i < NUM_THREADS; i++) begin
                    if (thread_queued[i]) pool.push_back(t_tid'(i));
                end
                if (pool.size() != 0 && $urandom_range(0, 4) != 0) begin
                    tid = pool[$urandom_range(0, pool.size() - 1)];
                end
            end else if (pick < 95) begin
                // A tick may only name a thread whose slice has been loaded.
                mode = MODE_TICK;
                for (int i = 0; i < NUM_THREADS; i++) begin
                    if (slice_loaded[i]) pool.push_back(t_tid'(i));
                end
                if (pick < 75 || pool.size() == 0) begin
                    mode = MODE_INIT;
                end else begin
                    tid = pool[$urandom_range(0, pool.size() - 1)];
                    rr  = ($urandom_range(0, 4) != 0);
                end
            end else begin
                mode = t_mode_bits'($urandom_range(5, 7));
            end
            send_request(mode, tid, prio, rr);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unknown_modes();
        test_get_next_empty();
        test_add_preempt();
        test_get_next();
        test_remove_positions();
        test_slice_reload();
        test_random_traffic(16'hFFFF, 200);
        test_random_traffic(16'd1, 200);
        test_random_traffic(t_slice'($urandom_range(2, 12)), 200);
        test_random_traffic(16'd0, 200);

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d init, %0d add, %0d remove, %0d get-next, %0d tick requests and %0d %s",
                 mode_count[MODE_INIT], mode_count[MODE_ADD], mode_count[MODE_REMOVE],
                 mode_count[MODE_NEXT], mode_count[MODE_TICK],
                 mode_count[5] + mode_count[6] + mode_count[7], "with undefined modes.");
        $display("Checked %0d results: %0d threads picked, %0d preemptions; %0d errors.",
                 results_checked, picks_seen, reschedules_seen, fail_count);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("** realtime_priority_run_queue: PASSED **");
        end else begin
            $display("** realtime_priority_run_queue: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rprq_pkg.sv
rtl/core/rprq_ram.sv
rtl/core/realtime_priority_run_queue.sv
test/tb_top.sv
